// ----- hdl/fsc_pkg.sv -----
// ============================================================================
// fsc_pkg: shared definitions for the fire-spread cell update
// Class codes, register indexes, the cell record and the configuration
// bundle, the distance rank of each neighbour lane and the spread weights.
// ============================================================================
package fsc_pkg;

    // Cell class codes. Code seven is unused and never spreads or ages.
    localparam logic [2:0] CLS_BARE      = 3'd0;
    localparam logic [2:0] CLS_IGNITION  = 3'd1;
    localparam logic [2:0] CLS_BURNING   = 3'd2;
    localparam logic [2:0] CLS_SMOULDER  = 3'd3;
    localparam logic [2:0] CLS_GRASSLAND = 3'd4;
    localparam logic [2:0] CLS_SAVANNA   = 3'd5;
    localparam logic [2:0] CLS_FOREST    = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SPREAD_COEF   = 3'd0;
    localparam logic [2:0] CFG_BASE_PROB     = 3'd1;
    localparam logic [2:0] CFG_DECAY_STEP    = 3'd2;
    localparam logic [2:0] CFG_BURN_LOAD     = 3'd3;
    localparam logic [2:0] CFG_SMOULDER_LOAD = 3'd4;

    // Phase change limits of the burn timer.
    localparam logic [7:0] IGNITION_LIMIT = 8'd2;
    localparam logic [7:0] BURNING_LIMIT  = 8'd6;
    localparam logic [7:0] SMOULDER_LIMIT = 8'd16;

    localparam int PROB_FRAC_BITS_DEF = 16;
    localparam int NUM_LANES          = 8;

    // Distance rank of each neighbour, NW,N,NE,W,E,SW,S,SE.
    localparam int RANK_OF [NUM_LANES] = '{1, 0, 1, 2, 2, 3, 4, 3};

    typedef struct packed {
        logic [2:0]         cls;
        logic [7:0]         timer;
        logic signed [15:0] since;
    } t_cell;

    typedef struct packed {
        logic [2:0]  spread_coef;
        logic [15:0] base_prob;
        logic [15:0] decay_step;
        logic [7:0]  burn_load;
        logic [7:0]  smoulder_load;
    } t_cfg;

    // Keeps the low frac_bits bits of a 16-bit probability.
    function automatic logic [15:0] prob_mask(input int frac_bits);
        logic [15:0] m;
        for (int b = 0; b < 16; b++) begin
            m[b] = (b < frac_bits);
        end
        return m;
    endfunction

    // Five times the neighbour intensity times five times the cell weight.
    // Zero when the neighbour is no fire or the cell is no vegetation.
    function automatic logic [4:0] spread_weight(input logic [2:0] nb_cls,
                                                 input logic [2:0] cell_cls);
        logic [4:0] i5;
        logic [4:0] w5;
        case (nb_cls)
            CLS_IGNITION: i5 = 5'd3;
            CLS_BURNING:  i5 = 5'd5;
            CLS_SMOULDER: i5 = 5'd1;
            default:      i5 = 5'd0;
        endcase
        case (cell_cls)
            CLS_GRASSLAND: w5 = 5'd3;
            CLS_SAVANNA:   w5 = 5'd5;
            CLS_FOREST:    w5 = 5'd4;
            default:       w5 = 5'd0;
        endcase
        return 5'(i5 * w5);
    endfunction

endpackage

// ----- hdl/fsc_age.sv -----
// ============================================================================
// fsc_age: cell ageing
// Advances the burn and since-burn timers and walks a fire cell through
// ignition, burning, smouldering and bare soil. Result is held in stage A.
// ============================================================================
module fsc_age
    import fsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  logic [2:0]         i_cls,
    input  logic [7:0]         i_timer,
    input  logic signed [15:0] i_since,
    output logic [2:0]         o_aged_cls,
    output t_cell              o_cell
);

    t_cell n_cell;
    t_cell r_cell;

    // Ageing steps run in order, so one beat may pass several phases.
    always_comb begin
        n_cell.cls   = i_cls;
        n_cell.timer = i_timer;
        n_cell.since = i_since;
        if ((i_cls == CLS_IGNITION || i_cls == CLS_BURNING || i_cls == CLS_SMOULDER)
            && i_timer != 8'hFF) begin
            n_cell.timer = i_timer + 8'd1;
        end
        if (i_cls == CLS_BARE && i_since != 16'sh7FFF) begin
            n_cell.since = i_since + 16'sd1;
        end
        if (n_cell.cls == CLS_IGNITION && n_cell.timer > IGNITION_LIMIT) begin
            n_cell.cls   = CLS_BURNING;
            n_cell.since = -16'sd1;
            n_cell.timer = i_cfg.burn_load;
        end
        if (n_cell.cls == CLS_BURNING && n_cell.timer > BURNING_LIMIT) begin
            n_cell.cls   = CLS_SMOULDER;
            n_cell.since = -16'sd1;
            n_cell.timer = i_cfg.smoulder_load;
        end
        if (n_cell.cls == CLS_SMOULDER && n_cell.timer > SMOULDER_LIMIT) begin
            n_cell.cls   = CLS_BARE;
            n_cell.since = 16'sd0;
            n_cell.timer = 8'd0;
        end
    end

    // Stage A holding register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_aged_cls = n_cell.cls;
    assign o_cell     = r_cell;

endmodule

// ----- hdl/fsc_lane.sv -----
// ============================================================================
// fsc_lane: one neighbour's spread test
// Stage A forms (base - decay*rank) * intensity * weight and 25 times the
// random fraction; stage B scales by the spread coefficient and compares.
// ============================================================================
module fsc_lane
    import fsc_pkg::*;
#(
    parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF,
    parameter int RANK           = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_cfg        i_cfg,
    input  logic [2:0]  i_cell_cls,
    input  logic [2:0]  i_nb_cls,
    input  logic [15:0] i_rand,
    output logic        o_hit
);

    localparam logic [15:0] MASK = prob_mask(PROB_FRAC_BITS);

    logic [15:0]        base_m;
    logic [15:0]        decay_m;
    logic [15:0]        rand_m;
    logic [18:0]        decay_rank;
    logic signed [19:0] diff;
    logic [4:0]         weight;
    logic signed [24:0] n_prod;
    logic [20:0]        n_r25;
    logic signed [24:0] r_prod;
    logic [20:0]        r_r25;
    logic signed [28:0] thr;

    // Stage A: rank-adjusted probability times the intensity and weight.
    always_comb begin
        base_m     = i_cfg.base_prob & MASK;
        decay_m    = i_cfg.decay_step & MASK;
        rand_m     = i_rand & MASK;
        decay_rank = 19'(decay_m) * 19'(RANK);
        diff       = $signed({4'b0, base_m}) - $signed({1'b0, decay_rank});
        weight     = spread_weight(i_nb_cls, i_cell_cls);
        n_prod     = 25'(diff) * $signed(25'(weight));
        n_r25      = (21'(rand_m) << 4) + (21'(rand_m) << 3) + 21'(rand_m);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_r25  <= n_r25;
        end
    end

    // Stage B: a negative threshold never fires since the fraction is non-negative.
    assign thr   = 29'(r_prod) * $signed(29'(i_cfg.spread_coef));
    assign o_hit = $signed({8'b0, r_r25}) < thr;

endmodule

// ----- hdl/fsc_merge.sv -----
// ============================================================================
// fsc_merge: lane merge and output register
// ORs the lane hits, applies ignition to the aged cell and holds the result
// beat until the receiver takes it.
// ============================================================================
module fsc_merge
    import fsc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [NUM_LANES-1:0]      i_hit,
    input  t_cell                     i_cell,
    input  logic                      i_stall,
    output logic                      o_ready,
    output logic                      o_valid,
    output t_cell                     o_cell
);

    logic  r_valid;
    t_cell r_cell;
    t_cell n_cell;

    // Any lane hit ignites the cell.
    always_comb begin
        n_cell = i_cell;
        if (|i_hit) begin
            n_cell.cls   = CLS_IGNITION;
            n_cell.timer = 8'd0;
            n_cell.since = -16'sd1;
        end
    end

    // The output register frees when empty or when its beat is taken.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// ----- hdl/fire_spread_cell_update.sv -----
// ============================================================================
// fire_spread_cell_update: forest-fire lattice cell update
// Ages one cell and tests its eight neighbours for fire spread in parallel
// lanes, then merges the lane results into the cell's next value.
// ============================================================================
// Usage:
// The input channel carries one cell per beat (i_valid, o_stall): its class,
// timers, eight neighbour classes and eight random fractions. The output
// channel (o_valid, i_stall) returns the updated cell, one beat per input.
// A beat is taken at a clock edge with valid high and stall low.
// An input beat passes stage A and stage B before output valid: stage A holds
// the aged cell and each lane's weighted probability, stage B scales, compares,
// merges and loads the output register. One cell is accepted every cycle
// while o_stall is low; each lane's stage A multiplier sets the clock.
// A held output beat does not stop stage A: a new cell is still taken while
// stage A is free, and o_stall rises only when both stages are full.
// Configuration writes (i_cfg_valid, o_cfg_ready, always ready) are registered
// and must only be made while the block is empty.
// Synchronous active-low reset empties both stages and loads the default
// register values; no clearing pass is needed.
// ============================================================================
module fire_spread_cell_update
    import fsc_pkg::*;
#(
    parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_cell_class,
    input  logic [7:0]         i_burn_timer,
    input  logic signed [15:0] i_since_burn_timer,
    input  logic [23:0]        i_neighbour_classes,
    input  logic [63:0]        i_random_upper,
    input  logic [63:0]        i_random_lower,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_new_class,
    output logic [7:0]         o_new_burn_timer,
    output logic signed [15:0] o_new_since_burn_timer,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cfg                 r_cfg;
    logic                 r_a_valid;
    logic                 a_ready;
    logic                 accept;
    logic [2:0]           aged_cls;
    t_cell                a_cell;
    t_cell                out_cell;
    logic [NUM_LANES-1:0] hit;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spread_coef   <= 3'd1;
            r_cfg.base_prob     <= 16'd10486;
            r_cfg.decay_step    <= 16'd2621;
            r_cfg.burn_load     <= 8'd3;
            r_cfg.smoulder_load <= 8'd7;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SPREAD_COEF:   r_cfg.spread_coef   <= i_cfg_data[2:0];
                CFG_BASE_PROB:     r_cfg.base_prob     <= i_cfg_data;
                CFG_DECAY_STEP:    r_cfg.decay_step    <= i_cfg_data;
                CFG_BURN_LOAD:     r_cfg.burn_load     <= i_cfg_data[7:0];
                CFG_SMOULDER_LOAD: r_cfg.smoulder_load <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Stage A takes a beat whenever it is empty or moving on.
    assign o_stall = r_a_valid && !a_ready;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_stall) begin
            r_a_valid <= i_valid;
        end
    end

    // Ageing of the centre cell.
    fsc_age u_age (
        .i_clk      (i_clk),
        .i_en       (accept),
        .i_cfg      (r_cfg),
        .i_cls      (i_cell_class),
        .i_timer    (i_burn_timer),
        .i_since    (i_since_burn_timer),
        .o_aged_cls (aged_cls),
        .o_cell     (a_cell)
    );

    // One spread lane per neighbour.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        logic [15:0] lane_rand;
        if (g < NUM_LANES / 2) begin : g_up
            assign lane_rand = i_random_upper[16*g +: 16];
        end else begin : g_lo
            assign lane_rand = i_random_lower[16*(g-NUM_LANES/2) +: 16];
        end
        fsc_lane #(
            .PROB_FRAC_BITS (PROB_FRAC_BITS),
            .RANK           (RANK_OF[g])
        ) u_lane (
            .i_clk      (i_clk),
            .i_en       (accept),
            .i_cfg      (r_cfg),
            .i_cell_cls (aged_cls),
            .i_nb_cls   (i_neighbour_classes[3*g +: 3]),
            .i_rand     (lane_rand),
            .o_hit      (hit[g])
        );
    end

    // Merge and output register.
    fsc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .i_hit   (hit),
        .i_cell  (a_cell),
        .i_stall (i_stall),
        .o_ready (a_ready),
        .o_valid (o_valid),
        .o_cell  (out_cell)
    );

    assign o_new_class            = out_cell.cls;
    assign o_new_burn_timer       = out_cell.timer;
    assign o_new_since_burn_timer = out_cell.since;

    // An accepted beat always occupies stage A on the next cycle.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_a_valid)
        else $error("accepted beat did not reach stage A");

    // The input side is never held off while stage A is empty.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> !o_stall)
        else $error("input stalled with stage A empty");

    // A stage A beat moves to the output when the receiver is not stalling.
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !i_stall |=> o_valid)
        else $error("stage A beat lost on the way to the output");

endmodule

// ----- tb/fire_spread_cell_update_tb.sv -----
// ============================================================================
// fire_spread_cell_update_tb: self-checking bench for the fire-spread cell update
// Drives cells through the input channel with random bursts and gaps, stalls
// the output channel on its own pattern and compares every returned cell
// with a behavioural prediction of the aging and neighbour spread rules.
// The register file is swept through several settings, the extremes included.
// ============================================================================
module fire_spread_cell_update_tb
    import fsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int        CLK_PERIOD    = 4;
    localparam int        RESET_CYCLES  = 11;
    localparam int        SETTLE_CYCLES = 6;
    localparam int        LONG_HOLD     = 50;
    localparam int        MAX_REPORTS   = 30;
    localparam int        PROB_BITS     = 16;
    localparam longint    PROB_MASK     = (longint'(1) << PROB_BITS) - 1;
    localparam logic [2:0] CLS_UNUSED   = 3'd7;
    // Register indexes that decode to nothing.
    localparam logic [2:0] CFG_FIRST_SPARE = 3'd5;
    localparam logic [2:0] CFG_LAST_SPARE  = 3'd7;
    localparam logic [63:0] ALL_HIGH    = 64'hFFFF_FFFF_FFFF_FFFF;
    // Distance rank of each neighbour lane, NW,N,NE,W,E,SW,S,SE.
    localparam int LANE_RANK [8] = '{1, 0, 1, 2, 2, 3, 4, 3};
    localparam logic [2:0] VEG_CLASSES  [3] = '{CLS_GRASSLAND, CLS_SAVANNA, CLS_FOREST};
    localparam logic [2:0] FIRE_CLASSES [3] = '{CLS_IGNITION, CLS_BURNING, CLS_SMOULDER};

    typedef struct packed {
        logic [2:0]         cls;
        logic [7:0]         timer;
        logic signed [15:0] since;
        logic [23:0]        nbrs;
        logic [63:0]        rnd_hi;
        logic [63:0]        rnd_lo;
    } t_cell_item;

    typedef struct packed {
        logic [2:0]         cls;
        logic [7:0]         timer;
        logic signed [15:0] since;
    } t_cell_state;

    typedef struct packed {
        logic [2:0]  coef;
        logic [15:0] base;
        logic [15:0] decay;
        logic [7:0]  burn_load;
        logic [7:0]  smoulder_load;
    } t_spread_regs;

    typedef enum {RX_FREE, RX_CHOPPY} t_rx_style;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_cell_class = '0;
    logic [7:0]         i_burn_timer = '0;
    logic signed [15:0] i_since_burn_timer = '0;
    logic [23:0]        i_neighbour_classes = '0;
    logic [63:0]        i_random_upper = '0;
    logic [63:0]        i_random_lower = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [2:0]         o_new_class;
    logic [7:0]         o_new_burn_timer;
    logic signed [15:0] o_new_since_burn_timer;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    t_spread_regs cfg_now = '{coef: 3'd1, base: 16'd10486, decay: 16'd2621,
                              burn_load: 8'd3, smoulder_load: 8'd7};
    t_cell_state  pending_cells [$];
    t_cell_state  trail_cell = '{cls: CLS_FOREST, timer: 8'd0, since: -16'sd1};
    t_rx_style    rx_style = RX_FREE;
    bit           hold_off_req = 1'b0;
    int           fail_count = 0;

    fire_spread_cell_update DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_cell_class           (i_cell_class),
        .i_burn_timer           (i_burn_timer),
        .i_since_burn_timer     (i_since_burn_timer),
        .i_neighbour_classes    (i_neighbour_classes),
        .i_random_upper         (i_random_upper),
        .i_random_lower         (i_random_lower),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_new_class            (o_new_class),
        .o_new_burn_timer       (o_new_burn_timer),
        .o_new_since_burn_timer (o_new_since_burn_timer),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Next value of one cell: aging first, then spread from neighbours on fire.
    function automatic t_cell_state predict_cell(input t_cell_item it);
        t_cell_state nxt;
        logic [2:0]  cls;
        logic [2:0]  ncls;
        logic [15:0] lane_frac;
        int          tmr;
        int          since;
        int          heat;
        int          fuel;
        longint      frac;
        longint      diff;
        longint      thr;
        bit          ignite;
        cls    = it.cls;
        tmr    = it.timer;
        since  = it.since;
        ignite = 1'b0;
        if (cls == CLS_IGNITION || cls == CLS_BURNING || cls == CLS_SMOULDER) begin
            if (tmr < 255) tmr++;
        end
        if (cls == CLS_BARE && since < 32767) since++;
        // The phase checks run in order, so one beat may cascade.
        if (cls == CLS_IGNITION && tmr > IGNITION_LIMIT) begin
            cls   = CLS_BURNING;
            since = -1;
            tmr   = cfg_now.burn_load;
        end
        if (cls == CLS_BURNING && tmr > BURNING_LIMIT) begin
            cls   = CLS_SMOULDER;
            since = -1;
            tmr   = cfg_now.smoulder_load;
        end
        if (cls == CLS_SMOULDER && tmr > SMOULDER_LIMIT) begin
            cls   = CLS_BARE;
            since = 0;
            tmr   = 0;
        end
        // Vegetation weight and neighbour intensity are both scaled by five.
        case (cls)
            CLS_GRASSLAND: fuel = 3;
            CLS_SAVANNA:   fuel = 5;
            CLS_FOREST:    fuel = 4;
            default:       fuel = 0;
        endcase
        if (fuel != 0) begin
            for (int lane = 0; lane < 8; lane++) begin
                ncls = it.nbrs[3*lane +: 3];
                case (ncls)
                    CLS_IGNITION: heat = 3;
                    CLS_BURNING:  heat = 5;
                    CLS_SMOULDER: heat = 1;
                    default:      heat = 0;
                endcase
                if (heat == 0) continue;
                lane_frac = (lane < 4) ? it.rnd_hi[16*lane +: 16] : it.rnd_lo[16*(lane-4) +: 16];
                frac = longint'(lane_frac) & PROB_MASK;
                diff = (longint'(cfg_now.base) & PROB_MASK)
                     - (longint'(cfg_now.decay) & PROB_MASK) * LANE_RANK[lane];
                thr  = longint'(cfg_now.coef) * diff * heat * fuel;
                if (frac * 25 < thr) ignite = 1'b1;
            end
        end
        if (ignite) begin
            cls   = CLS_IGNITION;
            tmr   = 0;
            since = -1;
        end
        nxt.cls   = cls;
        nxt.timer = tmr[7:0];
        nxt.since = since[15:0];
        return nxt;
    endfunction

    function automatic t_cell_item make_item(input logic [2:0] cls, input logic [7:0] timer,
                                             input logic signed [15:0] since,
                                             input logic [23:0] nbrs,
                                             input logic [63:0] rnd_hi,
                                             input logic [63:0] rnd_lo);
        t_cell_item it;
        it.cls    = cls;
        it.timer  = timer;
        it.since  = since;
        it.nbrs   = nbrs;
        it.rnd_hi = rnd_hi;
        it.rnd_lo = rnd_lo;
        return it;
    endfunction

    // Mostly follows one cell through its life; the rest are fresh cells.
    function automatic t_cell_item random_cell_item();
        t_cell_item  it;
        logic [15:0] frac;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 60 && trail_cell.cls != CLS_BARE && trail_cell.cls != CLS_UNUSED) begin
            it.cls   = trail_cell.cls;
            it.timer = trail_cell.timer;
            it.since = trail_cell.since;
        end else begin
            it.cls   = (pick < 80) ? VEG_CLASSES[$urandom_range(0, 2)]
                                   : 3'($urandom_range(0, 7));
            it.timer = (pick < 90) ? 8'($urandom_range(0, 20)) : 8'($urandom);
            if (pick >= 94)
                it.since = 16'($urandom);
            else if (it.cls == CLS_BARE)
                it.since = (pick % 2) ? 16'($urandom_range(0, 32767))
                                      : 16'($urandom_range(32760, 32767));
            else
                it.since = -16'sd1;
        end
        for (int lane = 0; lane < 8; lane++) begin
            it.nbrs[3*lane +: 3] = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
                0:       frac = 16'($urandom_range(0, 255));
                1:       frac = 16'($urandom_range(0, 16383));
                default: frac = 16'($urandom);
            endcase
            if (lane < 4) it.rnd_hi[16*lane +: 16] = frac;
            else          it.rnd_lo[16*(lane-4) +: 16] = frac;
        end
        return it;
    endfunction

    // One input beat; returns at the edge that accepts it.
    task automatic send_cell(input t_cell_item it);
        t_cell_state want;
        @(negedge i_clk);
        i_valid             <= 1'b1;
        i_cell_class        <= it.cls;
        i_burn_timer        <= it.timer;
        i_since_burn_timer  <= it.since;
        i_neighbour_classes <= it.nbrs;
        i_random_upper      <= it.rnd_hi;
        i_random_lower      <= it.rnd_lo;
        do @(posedge i_clk); while (o_stall);
        want = predict_cell(it);
        pending_cells.push_back(want);
        trail_cell = want;
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Drops valid and waits until every predicted cell has come back.
    task automatic wait_all_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SPREAD_COEF:   cfg_now.coef          = data[2:0];
            CFG_BASE_PROB:     cfg_now.base          = data;
            CFG_DECAY_STEP:    cfg_now.decay         = data;
            CFG_BURN_LOAD:     cfg_now.burn_load     = data[7:0];
            CFG_SMOULDER_LOAD: cfg_now.smoulder_load = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Writes the whole register file; unused upper data bits carry noise.
    task automatic load_settings(input logic [2:0] coef, input logic [15:0] base,
                                 input logic [15:0] decay, input logic [7:0] burn_load,
                                 input logic [7:0] smoulder_load);
        write_register(CFG_SPREAD_COEF, {13'($urandom), coef});
        write_register(CFG_BASE_PROB, base);
        write_register(CFG_DECAY_STEP, decay);
        write_register(CFG_BURN_LOAD, {8'($urandom), burn_load});
        write_register(CFG_SMOULDER_LOAD, {8'($urandom), smoulder_load});
    endtask

    task automatic send_random_items(input int count, input bit with_gaps);
        int burst_left;
        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < count; n++) begin
            send_cell(random_cell_item());
            if (with_gaps) begin
                burst_left--;
                if (burst_left == 0) begin
                    pause_sender($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 12);
                end
            end
        end
        wait_all_results();
    endtask

    // Phase changes, saturation and pass-through with no fire nearby.
    task automatic test_phase_aging();
        logic [23:0] calm;
        calm = {8{CLS_FOREST}};
        send_cell(make_item(CLS_IGNITION, 8'd0, -16'sd1, calm, ALL_HIGH, ALL_HIGH));
        send_cell(make_item(CLS_IGNITION, 8'd2, -16'sd1, calm, ALL_HIGH, ALL_HIGH));
        send_cell(make_item(CLS_IGNITION, 8'd255, 16'sd5, calm, ALL_HIGH, ALL_HIGH));
        send_cell(make_item(CLS_BURNING, 8'd6, -16'sd1, calm, ALL_HIGH, ALL_HIGH));
        send_cell(make_item(CLS_BURNING, 8'd0, -16'sd1, calm, ALL_HIGH, ALL_HIGH));
        send_cell(make_item(CLS_SMOULDER, 8'd16, -16'sd1, calm, ALL_HIGH, ALL_HIGH));
        send_cell(make_item(CLS_SMOULDER, 8'd255, -16'sd1, calm, ALL_HIGH, ALL_HIGH));
        send_cell(make_item(CLS_BARE, 8'd0, 16'sd32767, calm, ALL_HIGH, ALL_HIGH));
        send_cell(make_item(CLS_BARE, 8'd9, -16'sd1, calm, ALL_HIGH, ALL_HIGH));
        send_cell(make_item(CLS_BARE, 8'd0, -16'sd32768, calm, ALL_HIGH, ALL_HIGH));
        // The unused class keeps its fields even when surrounded by fire.
        send_cell(make_item(CLS_UNUSED, 8'd200, -16'sd300, {8{CLS_BURNING}}, '0, '0));
        send_cell(make_item(CLS_GRASSLAND, 8'd200, -16'sd5, calm, '0, '0));
        wait_all_results();
    endtask

    // Each neighbour lane alone, the threshold boundary and the non-spreading cases.
    task automatic test_lane_spread();
        logic [23:0] nbrs;
        logic [63:0] hi;
        logic [63:0] lo;
        for (int lane = 0; lane < 8; lane++) begin
            nbrs = {8{CLS_GRASSLAND}};
            nbrs[3*lane +: 3] = FIRE_CLASSES[lane % 3];
            hi = ALL_HIGH;
            lo = ALL_HIGH;
            if (lane < 4) hi[16*lane +: 16] = '0;
            else          lo[16*(lane-4) +: 16] = '0;
            send_cell(make_item(VEG_CLASSES[lane % 3], 8'd0, -16'sd1, nbrs, hi, lo));
        end
        // North burning onto forest: the threshold sits between 8388 and 8389.
        nbrs = {8{CLS_GRASSLAND}};
        nbrs[5:3] = CLS_BURNING;
        send_cell(make_item(CLS_FOREST, 8'd4, -16'sd1, nbrs,
                            {16'hFFFF, 16'hFFFF, 16'd8388, 16'hFFFF}, ALL_HIGH));
        send_cell(make_item(CLS_FOREST, 8'd4, -16'sd1, nbrs,
                            {16'hFFFF, 16'hFFFF, 16'd8389, 16'hFFFF}, ALL_HIGH));
        send_cell(make_item(CLS_SAVANNA, 8'd0, -16'sd1, {8{CLS_BURNING}}, ALL_HIGH, ALL_HIGH));
        send_cell(make_item(CLS_SAVANNA, 8'd0, -16'sd1, {8{CLS_UNUSED}}, '0, '0));
        send_cell(make_item(CLS_BARE, 8'd0, 16'sd3, {8{CLS_BURNING}}, '0, '0));
        send_cell(make_item(CLS_BURNING, 8'd0, -16'sd1, {8{CLS_BURNING}}, '0, '0));
        wait_all_results();
    endtask

    // Register extremes: no spread, maximum spread, negative thresholds,
    // timer loads that cascade through several phases, then random settings.
    task automatic test_register_extremes();
        rx_style = RX_CHOPPY;
        load_settings(3'd0, 16'd10486, 16'd2621, 8'd0, 8'd0);
        send_random_items(80, 1'b1);
        load_settings(3'd6, 16'hFFFF, 16'h0000, 8'd255, 8'd255);
        send_random_items(80, 1'b1);
        load_settings(3'd6, 16'h0000, 16'hFFFF, 8'd7, 8'd17);
        send_random_items(80, 1'b1);
        repeat (2) begin
            load_settings(3'($urandom_range(0, 6)), 16'($urandom), 16'($urandom),
                          8'($urandom), 8'($urandom));
            send_random_items(80, 1'b1);
        end
    endtask

    // Writes to indexes beyond the register file must change nothing.
    task automatic test_spare_register_indexes();
        load_settings(3'd2, 16'd20000, 16'd3000, 8'd4, 8'd12);
        for (int k = CFG_FIRST_SPARE; k <= CFG_LAST_SPARE; k++) begin
            write_register(3'(k), 16'($urandom));
        end
        send_random_items(60, 1'b1);
    endtask

    // A quiet stretch at full rate, then bursts with a choppy receiver.
    task automatic test_random_traffic();
        load_settings(3'd1, 16'd10486, 16'd2621, 8'd3, 8'd7);
        rx_style = RX_FREE;
        send_random_items(100, 1'b0);
        rx_style = RX_CHOPPY;
        send_random_items(300, 1'b1);
    endtask

    // The receiver holds off long enough for both stages to fill.
    task automatic test_backpressure();
        rx_style     = RX_FREE;
        hold_off_req = 1'b1;
        send_random_items(60, 1'b0);
        rx_style     = RX_CHOPPY;
    endtask

    // Receiver pacing: free, choppy runs, or one long hold-off on request.
    initial begin : rx_pacing
        bit stalled;
        int run_left;
        stalled  = 1'b0;
        run_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_off_req = 1'b0;
                i_stall <= 1'b0;
            end else if (rx_style == RX_CHOPPY) begin
                if (run_left == 0) begin
                    stalled  = !stalled;
                    run_left = stalled ? $urandom_range(1, 4) : $urandom_range(1, 10);
                end
                run_left--;
                i_stall <= stalled;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Every output beat is matched against the oldest predicted cell.
    always @(posedge i_clk) begin : check_results
        t_cell_state want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_cells.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: output beat with nothing expected, class %0d", $time,
                             o_new_class);
                fail_count++;
            end else begin
                want = pending_cells.pop_front();
                if (o_new_class !== want.cls || o_new_burn_timer !== want.timer ||
                    o_new_since_burn_timer !== want.since) begin
                    if (fail_count < MAX_REPORTS) begin
                        if (o_new_class !== want.cls)
                            $display("%0t: class mismatch, expected %0d, got %0d",
                                     $time, want.cls, o_new_class);
                        if (o_new_burn_timer !== want.timer)
                            $display("%0t: burn timer mismatch, expected %0d, got %0d",
                                     $time, want.timer, o_new_burn_timer);
                        if (o_new_since_burn_timer !== want.since)
                            $display("%0t: since-burn mismatch, expected %0d, got %0d",
                                     $time, want.since, o_new_since_burn_timer);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_phase_aging();
        test_lane_spread();
        test_register_extremes();
        test_spare_register_indexes();
        test_random_traffic();
        test_backpressure();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
